FILE: sv/ssrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI sensor register master: shared definitions
// Command codes, sensor register addresses and the result record that passes
// from the frame engine to the output buffer.
// ----------------------------------------------------------------------------
package ssrm_pkg;

   localparam int unsigned DIVIDER_WIDTH_DEFAULT = 10;
   localparam int unsigned HALF_PERIOD_RESET     = 16;

   // Command codes carried in the mode field.
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_ACCEL = 2'd2;
   localparam logic [1:0] MODE_GYRO  = 2'd3;

   // High-byte register addresses of the x axis; y and z follow in steps of two.
   localparam logic [6:0] ACCEL_BASE = 7'h3B;
   localparam logic [6:0] GYRO_BASE  = 7'h43;
   localparam logic       READ_FLAG  = 1'b1;

   typedef struct packed {
      logic               cs_n;
      logic               sclk;
      logic               mosi;
      logic               busy_res;
      logic               done_res;
      logic [7:0]         byte_value;
      logic signed [15:0] axis_value;
   } result_type;

endpackage
`default_nettype wire

FILE: sv/ssrm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI sensor register master: frame engine
// Advances the mode 3 bus sequencer by one system tick per transaction and
// presents the pin levels and status that follow that tick.
// ----------------------------------------------------------------------------
module ssrm_engine #(
   parameter int unsigned DIVIDER_WIDTH = ssrm_pkg::DIVIDER_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic                     start_req,
   input  wire logic [1:0]               mode,
   input  wire logic [1:0]               axis,
   input  wire logic [6:0]               reg_addr,
   input  wire logic [7:0]               wr_data,
   input  wire logic                     miso,
   input  wire logic [DIVIDER_WIDTH-1:0] half_period,
   output ssrm_pkg::result_type          result
);
   import ssrm_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETUP,
      PH_LOW,
      PH_HIGH,
      PH_GAP
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [DIVIDER_WIDTH-1:0] tick_ff, tick_in;
   logic [3:0]             bit_index_ff, bit_index_in;
   logic [15:0]            frame_shift_ff, frame_shift_in;
   logic [7:0]             receive_shift_ff, receive_shift_in;
   logic [1:0]             job_kind_ff, job_kind_in;
   logic                   second_frame_ff, second_frame_in;
   logic [7:0]             high_byte_ff, high_byte_in;
   logic [6:0]             frame_addr_ff, frame_addr_in;
   logic [7:0]             last_byte_ff, last_byte_in;
   logic [15:0]            last_axis_ff, last_axis_in;

   logic [DIVIDER_WIDTH:0]   tick_plus;
   logic [DIVIDER_WIDTH-1:0] hp_eff;
   logic                     phase_end;
   logic [DIVIDER_WIDTH-1:0] tick_adv;
   logic                     axis_job;
   logic [6:0]               axis_addr;
   logic                     done;
   logic [3:0]               mosi_sel;

   // A half period of zero counts as one tick.
   assign hp_eff    = (half_period == '0) ? DIVIDER_WIDTH'(1) : half_period;
   assign tick_plus = {1'b0, tick_ff} + (DIVIDER_WIDTH + 1)'(1);
   assign phase_end = tick_plus >= {1'b0, hp_eff};
   assign tick_adv  = phase_end ? '0 : tick_plus[DIVIDER_WIDTH-1:0];
   assign axis_job  = (job_kind_ff == MODE_ACCEL) || (job_kind_ff == MODE_GYRO);
   assign axis_addr = ((mode == MODE_ACCEL) ? ACCEL_BASE : GYRO_BASE) + {4'b0, axis, 1'b0};

   always_comb begin
      phase_in         = phase_ff;
      tick_in          = tick_ff;
      bit_index_in     = bit_index_ff;
      frame_shift_in   = frame_shift_ff;
      receive_shift_in = receive_shift_ff;
      job_kind_in      = job_kind_ff;
      second_frame_in  = second_frame_ff;
      high_byte_in     = high_byte_ff;
      frame_addr_in    = frame_addr_ff;
      last_byte_in     = last_byte_ff;
      last_axis_in     = last_axis_ff;
      done             = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               job_kind_in      = mode;
               second_frame_in  = 1'b0;
               receive_shift_in = '0;
               case (mode)
                  MODE_WRITE: begin
                     frame_addr_in  = reg_addr;
                     frame_shift_in = {1'b0, reg_addr, wr_data};
                  end
                  MODE_READ: begin
                     frame_addr_in  = reg_addr;
                     frame_shift_in = {READ_FLAG, reg_addr, 8'h00};
                  end
                  default: begin
                     frame_addr_in  = axis_addr;
                     frame_shift_in = {READ_FLAG, axis_addr, 8'h00};
                  end
               endcase
               tick_in      = '0;
               bit_index_in = '0;
               phase_in     = PH_SETUP;
            end
         end
         PH_SETUP: begin
            tick_in = tick_adv;
            if (phase_end) begin
               bit_index_in = '0;
               phase_in     = PH_LOW;
            end
         end
         PH_LOW: begin
            tick_in = tick_adv;
            if (phase_end) begin
               // Rising edge of sclk: the data byte is sampled from miso.
               if (bit_index_ff[3]) begin
                  receive_shift_in = {receive_shift_ff[6:0], miso};
               end
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            tick_in = tick_adv;
            if (phase_end) begin
               if (bit_index_ff != 4'd15) begin
                  bit_index_in = bit_index_ff + 4'd1;
                  phase_in     = PH_LOW;
               end else if (axis_job && !second_frame_ff) begin
                  // First frame of an axis read done: fetch the low register next.
                  high_byte_in     = receive_shift_ff;
                  second_frame_in  = 1'b1;
                  receive_shift_in = '0;
                  frame_addr_in    = frame_addr_ff + 7'd1;
                  frame_shift_in   = {READ_FLAG, frame_addr_ff + 7'd1, 8'h00};
                  bit_index_in     = '0;
                  phase_in         = PH_GAP;
               end else begin
                  if (job_kind_ff == MODE_READ) begin
                     last_byte_in = receive_shift_ff;
                  end else if (axis_job) begin
                     last_axis_in = {high_byte_ff, receive_shift_ff};
                  end
                  bit_index_in = '0;
                  done         = 1'b1;
                  phase_in     = PH_IDLE;
               end
            end
         end
         PH_GAP: begin
            tick_in = tick_adv;
            if (phase_end) begin
               phase_in = PH_SETUP;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase
   end

   assign mosi_sel = 4'd15 - bit_index_in;

   always_comb begin
      result.cs_n       = 1'b1;
      result.sclk       = 1'b1;
      result.mosi       = 1'b0;
      result.busy_res   = (phase_in != PH_IDLE);
      result.done_res   = done;
      result.byte_value = last_byte_in;
      result.axis_value = last_axis_in;
      if (phase_in == PH_SETUP) begin
         result.cs_n = 1'b0;
      end else if ((phase_in == PH_LOW) || (phase_in == PH_HIGH)) begin
         result.cs_n = 1'b0;
         result.sclk = (phase_in == PH_HIGH);
         result.mosi = frame_shift_in[mosi_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         tick_ff          <= '0;
         bit_index_ff     <= '0;
         frame_shift_ff   <= '0;
         receive_shift_ff <= '0;
         job_kind_ff      <= '0;
         second_frame_ff  <= 1'b0;
         high_byte_ff     <= '0;
         frame_addr_ff    <= '0;
         last_byte_ff     <= '0;
         last_axis_ff     <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         tick_ff          <= tick_in;
         bit_index_ff     <= bit_index_in;
         frame_shift_ff   <= frame_shift_in;
         receive_shift_ff <= receive_shift_in;
         job_kind_ff      <= job_kind_in;
         second_frame_ff  <= second_frame_in;
         high_byte_ff     <= high_byte_in;
         frame_addr_ff    <= frame_addr_in;
         last_byte_ff     <= last_byte_in;
         last_axis_ff     <= last_axis_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/spi_sensor_register_master.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted tick's result is registered into the main or, if main is held, skid entry.
// One tick per cycle while req_ready is high; sequencer state updates in a single pass.
// A two-entry output buffer lets a new tick be taken while one result still waits.
// Synchronous reset returns the bus to idle (cs_n and sclk high, mosi low), clears
// the stored read values and loads a half period of 16 ticks.
// ----------------------------------------------------------------------------
// SPI sensor register master
// Mode 3 SPI master that drives register reads, writes and two-frame axis
// reads of a motion sensor, one system tick per input transaction.
// ----------------------------------------------------------------------------
module spi_sensor_register_master #(
   parameter int unsigned DIVIDER_WIDTH = ssrm_pkg::DIVIDER_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic                     req_start_req,
   input  wire logic [1:0]               req_mode,
   input  wire logic [1:0]               req_axis,
   input  wire logic [6:0]               req_reg_addr,
   input  wire logic [7:0]               req_wr_data,
   input  wire logic                     req_miso,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic                     rsp_cs_n,
   output      logic                     rsp_sclk,
   output      logic                     rsp_mosi,
   output      logic                     rsp_busy_res,
   output      logic                     rsp_done_res,
   output      logic [7:0]               rsp_byte_value,
   output      logic signed [15:0]       rsp_axis_value,
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [DIVIDER_WIDTH-1:0] csr_half_period
);
   import ssrm_pkg::*;

   logic [DIVIDER_WIDTH-1:0] half_period_ff;
   result_type               result;
   result_type               main_ff, main_in;
   result_type               skid_ff, skid_in;
   logic                     main_valid_ff, main_valid_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic                     accept;
   logic                     take;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign take      = main_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= DIVIDER_WIDTH'(HALF_PERIOD_RESET);
      end else if (csr_valid) begin
         half_period_ff <= csr_half_period;
      end
   end

   ssrm_engine #(
      .DIVIDER_WIDTH(DIVIDER_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .start_req   (req_start_req),
      .mode        (req_mode),
      .axis        (req_axis),
      .reg_addr    (req_reg_addr),
      .wr_data     (req_wr_data),
      .miso        (req_miso),
      .half_period (half_period_ff),
      .result      (result)
   );

   // The skid entry only fills when the main entry is held by a stalled consumer.
   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            main_in = result;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (main_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = result;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = main_valid_ff;
   assign rsp_cs_n       = main_ff.cs_n;
   assign rsp_sclk       = main_ff.sclk;
   assign rsp_mosi       = main_ff.mosi;
   assign rsp_busy_res   = main_ff.busy_res;
   assign rsp_done_res   = main_ff.done_res;
   assign rsp_byte_value = main_ff.byte_value;
   assign rsp_axis_value = main_ff.axis_value;

endmodule
`default_nettype wire

FILE: sv/ssrm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI sensor register master: port checker
// Watches the top-level ports for bus idle levels and result hold and status rules.
// ----------------------------------------------------------------------------
module ssrm_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_cs_n,
   input wire logic               rsp_sclk,
   input wire logic               rsp_mosi,
   input wire logic               rsp_busy_res,
   input wire logic               rsp_done_res,
   input wire logic [7:0]         rsp_byte_value,
   input wire logic signed [15:0] rsp_axis_value
);

   // A result that is not taken stays presented unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cs_n) && $stable(rsp_sclk)
         && $stable(rsp_mosi) && $stable(rsp_byte_value) && $stable(rsp_axis_value))
      else $error("result changed while stalled");

   // The finishing tick already shows the bus back at idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while busy");

   // With no command running, the pins sit at their idle levels.
   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_cs_n && rsp_sclk && !rsp_mosi)
      else $error("bus not idle outside a command");

   // Serial clock only toggles while chip select is asserted.
   a_sclk_cs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sclk |-> !rsp_cs_n && rsp_busy_res)
      else $error("sclk low with chip select released");

endmodule

bind spi_sensor_register_master ssrm_checker u_ssrm_checker (.*);
`default_nettype wire
